// ===== rtl/ucdp_pkg.sv =====
package ucdp_pkg;

   localparam int EP_NUMBERS = 16;
   localparam int EP_NUM_W   = $clog2(EP_NUMBERS);

   localparam logic [3:0] MAX_INTERFACES   = 4'd8;
   localparam logic [4:0] MAX_EP_PER_IFACE = 5'd16;

   localparam logic [7:0] EP0_RESET_SIZE = 8'd64;
   localparam logic [8:0] NO_IFACE       = 9'h100;

   localparam logic [7:0] DT_CONFIG    = 8'h02;
   localparam logic [7:0] DT_INTERFACE = 8'h04;
   localparam logic [7:0] DT_ENDPOINT  = 8'h05;
   localparam logic [7:0] DT_SS_COMP   = 8'h30;

   typedef enum logic [3:0] {
      EV_CONFIG_OK  = 4'd0,
      EV_NEW_IFACE  = 4'd1,
      EV_ALT_SET    = 4'd2,
      EV_ENDPOINT   = 4'd3,
      EV_SS_COMP    = 4'd4,
      EV_OTHER      = 4'd5,
      EV_ZERO_LEN   = 4'd6,
      EV_NOT_CONFIG = 4'd7,
      EV_ERROR      = 4'd8
   } event_kind_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first;
   } req_type;

   typedef struct packed {
      logic [3:0]  event_kind;
      logic [2:0]  interface_slot;
      logic [3:0]  interface_count;
      logic [7:0]  alt_count;
      logic [4:0]  endpoint_slot;
      logic [3:0]  endpoint_number;
      logic        is_in;
      logic [15:0] max_packet_in;
      logic [15:0] max_packet_out;
      logic        done_res;
   } rsp_type;

   // one decoded descriptor event, handed from the walker to the table stage
   typedef struct packed {
      logic                has_result;
      event_kind_type      kind;
      logic [2:0]          iface_slot;
      logic [3:0]          iface_count;
      logic [7:0]          alt_count;
      logic [4:0]          ep_slot;
      logic                is_ep;
      logic                ep_allowed;
      logic                ep_ctrl;
      logic                is_in;
      logic [EP_NUM_W-1:0] epn;
      logic [15:0]         ep_size;
      logic                done;
   } walk_event_type;

endpackage

// ===== rtl/ucdp_walker.sv =====
module ucdp_walker (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  ucdp_pkg::req_type       req,
   output ucdp_pkg::walk_event_type walk_ev,
   output logic                    active
);

   logic        active_ff, active_in;
   logic [7:0]  pos_ff, pos_in;
   logic [15:0] total_ff, total_in;
   logic [15:0] start_ff, start_in;
   logic [7:0]  len_ff, len_in;
   logic [7:0]  type_ff, type_in;
   logic [31:0] fields_ff, fields_in;
   logic [7:0]  decl_if_ff, decl_if_in;
   logic [3:0]  ic_ff, ic_in;
   logic [8:0]  cur_if_ff, cur_if_in;
   logic [7:0]  decl_ep_ff, decl_ep_in;
   logic [4:0]  ep_ff, ep_in;
   logic [7:0]  alt_ff, alt_in;

   logic        live, hdr, end_hit, at_end, done;
   logic [7:0]  pos_e, len_e, type_e, decl_if_e, decl_ep_e, alt_e;
   logic [15:0] total_e, start_e;
   logic [31:0] fields_e;
   logic [3:0]  ic_e;
   logic [8:0]  cur_if_e;
   logic [4:0]  ep_e;
   logic [16:0] next_start;
   ucdp_pkg::walk_event_type ev;

   always_comb begin
      live      = req.first | active_ff;
      // a first byte sees the cleared walk
      pos_e     = req.first ? 8'd0 : pos_ff;
      total_e   = req.first ? 16'd0 : total_ff;
      start_e   = req.first ? 16'd0 : start_ff;
      len_e     = req.first ? 8'd0 : len_ff;
      type_e    = req.first ? 8'd0 : type_ff;
      fields_e  = req.first ? 32'd0 : fields_ff;
      decl_if_e = req.first ? 8'd0 : decl_if_ff;
      ic_e      = req.first ? 4'd0 : ic_ff;
      cur_if_e  = req.first ? ucdp_pkg::NO_IFACE : cur_if_ff;
      decl_ep_e = req.first ? 8'd0 : decl_ep_ff;
      ep_e      = req.first ? 5'd0 : ep_ff;
      alt_e     = req.first ? 8'd0 : alt_ff;

      len_in     = len_e;
      type_in    = type_e;
      fields_in  = fields_e;
      total_in   = total_e;
      start_in   = start_e;
      pos_in     = pos_e;
      decl_if_in = decl_if_e;
      ic_in      = ic_e;
      cur_if_in  = cur_if_e;
      decl_ep_in = decl_ep_e;
      ep_in      = ep_e;
      alt_in     = alt_e;

      case (pos_e)
         8'd0: begin
            len_in    = req.data_byte;
            type_in   = 8'd0;
            fields_in = 32'd0;
         end
         8'd1: type_in = req.data_byte;
         8'd2: fields_in[7:0]   = fields_e[7:0]   | req.data_byte;
         8'd3: fields_in[15:8]  = fields_e[15:8]  | req.data_byte;
         8'd4: fields_in[23:16] = fields_e[23:16] | req.data_byte;
         8'd5: fields_in[31:24] = fields_e[31:24] | req.data_byte;
         default: ;
      endcase

      ev            = '0;
      ev.kind       = ucdp_pkg::EV_OTHER;
      at_end        = 1'b0;
      done          = 1'b0;
      hdr           = (start_e == 16'd0);
      end_hit       = ({1'b0, pos_e} + 9'd1) == {1'b0, len_in};

      if (len_in == 8'd0) begin
         ev.has_result = 1'b1;
         ev.kind       = ucdp_pkg::EV_ZERO_LEN;
         done          = 1'b1;
      end else if (hdr && pos_e == 8'd0 && len_in == 8'd1) begin
         ev.has_result = 1'b1;
         ev.kind       = ucdp_pkg::EV_NOT_CONFIG;
         done          = 1'b1;
      end else if (hdr && pos_e == 8'd1 && type_in != ucdp_pkg::DT_CONFIG) begin
         ev.has_result = 1'b1;
         ev.kind       = ucdp_pkg::EV_NOT_CONFIG;
         done          = 1'b1;
      end else if (end_hit) begin
         at_end        = 1'b1;
         ev.has_result = 1'b1;
         if (hdr) begin
            total_in   = fields_in[15:0];
            decl_if_in = fields_in[23:16];
            ev.kind    = ucdp_pkg::EV_CONFIG_OK;
         end else begin
            case (type_in)
               ucdp_pkg::DT_INTERFACE: begin
                  if ({1'b0, fields_in[7:0]} != cur_if_e) begin
                     if (ic_e >= ucdp_pkg::MAX_INTERFACES) begin
                        ev.kind = ucdp_pkg::EV_ERROR;
                        done    = 1'b1;
                     end else begin
                        ic_in      = ic_e + 4'd1;
                        alt_in     = 8'd1;
                        ep_in      = 5'd0;
                        decl_ep_in = fields_in[23:16];
                        cur_if_in  = {1'b0, fields_in[7:0]};
                        ev.kind    = ucdp_pkg::EV_NEW_IFACE;
                     end
                  end else begin
                     if (alt_e != 8'hFF) alt_in = alt_e + 8'd1;
                     ev.kind = ucdp_pkg::EV_ALT_SET;
                  end
               end
               ucdp_pkg::DT_ENDPOINT: begin
                  if (ic_e == 4'd0 || ep_e >= ucdp_pkg::MAX_EP_PER_IFACE) begin
                     ev.kind = ucdp_pkg::EV_ERROR;
                     done    = 1'b1;
                  end else begin
                     ev.kind       = ucdp_pkg::EV_ENDPOINT;
                     ev.is_ep      = 1'b1;
                     ev.epn        = fields_in[ucdp_pkg::EP_NUM_W-1:0];
                     ev.is_in      = fields_in[7];
                     ev.ep_ctrl    = (fields_in[9:8] == 2'd0);
                     ev.ep_size    = fields_in[31:16];
                     // endpoints past the declared counts are reported only
                     ev.ep_allowed = (({4'd0, ic_e} - 8'd1) < decl_if_e) &&
                                     ({3'd0, ep_e} < decl_ep_e);
                     ep_in         = ep_e + 5'd1;
                  end
               end
               ucdp_pkg::DT_SS_COMP: begin
                  if (ic_e == 4'd0 || ep_e == 5'd0) begin
                     ev.kind = ucdp_pkg::EV_ERROR;
                     done    = 1'b1;
                  end else begin
                     ev.kind = ucdp_pkg::EV_SS_COMP;
                  end
               end
               default: ev.kind = ucdp_pkg::EV_OTHER;
            endcase
         end
      end

      next_start = {1'b0, start_e} + {9'd0, len_in};
      if (at_end && !done) begin
         if (({1'b0, next_start} + 18'd1) >= {2'd0, total_in}) begin
            done = 1'b1;
         end else begin
            start_in = next_start[15:0];
            pos_in   = 8'd0;
         end
      end else if (!done) begin
         pos_in = pos_e + 8'd1;
      end
      active_in = !done;

      ev.has_result  = ev.has_result & live;
      ev.done        = done;
      ev.iface_count = ic_in;
      ev.iface_slot  = (ic_in == 4'd0) ? 3'd0 : 3'(ic_in - 4'd1);
      ev.alt_count   = alt_in;
      ev.ep_slot     = ep_in;
      walk_ev        = ev;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= 1'b0;
         pos_ff     <= '0;
         total_ff   <= '0;
         start_ff   <= '0;
         len_ff     <= '0;
         type_ff    <= '0;
         fields_ff  <= '0;
         decl_if_ff <= '0;
         ic_ff      <= '0;
         cur_if_ff  <= ucdp_pkg::NO_IFACE;
         decl_ep_ff <= '0;
         ep_ff      <= '0;
         alt_ff     <= '0;
      end else if (accept && live) begin
         active_ff  <= active_in;
         pos_ff     <= pos_in;
         total_ff   <= total_in;
         start_ff   <= start_in;
         len_ff     <= len_in;
         type_ff    <= type_in;
         fields_ff  <= fields_in;
         decl_if_ff <= decl_if_in;
         ic_ff      <= ic_in;
         cur_if_ff  <= cur_if_in;
         decl_ep_ff <= decl_ep_in;
         ep_ff      <= ep_in;
         alt_ff     <= alt_in;
      end
   end

   assign active = active_ff;

endmodule

// ===== rtl/ucdp_ep_table.sv =====
module ucdp_ep_table (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              rd_en,
   input  logic [ucdp_pkg::EP_NUM_W-1:0]     rd_addr,
   input  logic                              clear,
   input  logic [7:0]                        ep0_size,
   input  ucdp_pkg::walk_event_type          s1,
   input  logic                              fire,
   output logic [15:0]                       mp_in,
   output logic [15:0]                       mp_out
);

   logic [15:0] in_mem  [ucdp_pkg::EP_NUMBERS];
   logic [15:0] out_mem [ucdp_pkg::EP_NUMBERS];
   logic [15:0] in_rd_ff, out_rd_ff;
   logic [ucdp_pkg::EP_NUMBERS-1:0] vld_ff;
   // entry zero keeps the size that was current when the set started
   logic [7:0]  ep0_set_ff;

   logic [15:0] dflt, cur_in, cur_out, new_in, new_out;
   logic        wr_en;

   // rows not written since the last clear read as zero, but for row zero, which reads the kept ep0 size
   always_comb begin
      dflt    = (s1.epn == '0) ? {8'd0, ep0_set_ff} : 16'd0;
      cur_in  = vld_ff[s1.epn] ? in_rd_ff  : dflt;
      cur_out = vld_ff[s1.epn] ? out_rd_ff : dflt;
      new_in  = cur_in;
      new_out = cur_out;
      if (s1.ep_allowed) begin
         if (s1.ep_ctrl) begin
            new_in  = s1.ep_size;
            new_out = s1.ep_size;
         end else if (s1.is_in) begin
            if (s1.ep_size > cur_in) new_in = s1.ep_size;
         end else begin
            if (s1.ep_size > cur_out) new_out = s1.ep_size;
         end
      end
      wr_en  = fire && s1.is_ep && s1.ep_allowed;
      mp_in  = s1.is_ep ? new_in  : 16'd0;
      mp_out = s1.is_ep ? new_out : 16'd0;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         in_mem[s1.epn]  <= new_in;
         out_mem[s1.epn] <= new_out;
      end
      if (rd_en) begin
         in_rd_ff  <= in_mem[rd_addr];
         out_rd_ff <= out_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         ep0_set_ff <= ucdp_pkg::EP0_RESET_SIZE;
      end else if (clear) begin
         vld_ff     <= '0;
         ep0_set_ff <= ep0_size;
      end else if (wr_en) begin
         vld_ff[s1.epn] <= 1'b1;
      end
   end

   // two endpoint descriptors are at least two beats apart, so the write of one
   // always lands before the read of the next
   a_no_rd_wr_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rd_en && wr_en))
      else $error("endpoint table read and write in the same cycle");

endmodule

// ===== rtl/usb_config_descriptor_parser.sv =====
// Channel   Ports                                   Beat
// -------   -------------------------------------   ------------------------------
// request   req_valid, req_stall, req_data          one descriptor byte, first flag
// response  rsp_valid, rsp_stall, rsp_data          one descriptor event
// csr       csr_wr_en, csr_wr_data                  ep0 max packet size
//
// One byte per cycle while req_stall is low; an event is registered in the event stage, then in rsp_data.
// The endpoint tables are 16-entry synchronous RAMs, read when an endpoint byte is
// taken and updated in the following stage.
// Reset is synchronous, active high; the csr register returns to 64.
// rsp_stall backs up through the event stage into req_stall.
module usb_config_descriptor_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ucdp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ucdp_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic [7:0]        csr_wr_data
);

   logic [7:0] ep0_ff;

   logic                     accept, walk_active, rsp_free, s1_fire;
   ucdp_pkg::walk_event_type walk_ev;
   logic                     s1_valid_ff, s1_valid_in;
   ucdp_pkg::walk_event_type s1_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   ucdp_pkg::rsp_type        rsp_data_ff, rsp_data_in;
   logic [15:0]              mp_in, mp_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         ep0_ff <= ucdp_pkg::EP0_RESET_SIZE;
      end else if (csr_wr_en) begin
         ep0_ff <= csr_wr_data;
      end
   end

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_fire   = s1_valid_ff && rsp_free;
   assign req_stall = s1_valid_ff && !rsp_free;
   assign accept    = req_valid && !req_stall;

   ucdp_walker u_walker (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .req     (req_data),
      .walk_ev (walk_ev),
      .active  (walk_active)
   );

   ucdp_ep_table u_table (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (accept && walk_ev.has_result && walk_ev.is_ep),
      .rd_addr  (walk_ev.epn),
      .clear    (accept && req_data.first),
      .ep0_size (ep0_ff),
      .s1       (s1_ff),
      .fire     (s1_fire),
      .mp_in    (mp_in),
      .mp_out   (mp_out)
   );

   always_comb begin
      if (accept) begin
         s1_valid_in = walk_ev.has_result;
      end else begin
         s1_valid_in = s1_valid_ff && !s1_fire;
      end

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (s1_fire) begin
         rsp_valid_in                = 1'b1;
         rsp_data_in.event_kind      = s1_ff.kind;
         rsp_data_in.interface_slot  = s1_ff.iface_slot;
         rsp_data_in.interface_count = s1_ff.iface_count;
         rsp_data_in.alt_count       = s1_ff.alt_count;
         rsp_data_in.endpoint_slot   = s1_ff.ep_slot;
         rsp_data_in.endpoint_number = s1_ff.epn;
         rsp_data_in.is_in           = s1_ff.is_in;
         rsp_data_in.max_packet_in   = mp_in;
         rsp_data_in.max_packet_out  = mp_out;
         rsp_data_in.done_res        = s1_ff.done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) s1_ff <= walk_ev;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_fire_lands: assert property (@(posedge clock) disable iff (reset)
      s1_fire |=> rsp_valid_ff)
      else $error("event stage fired but output register is empty");

   a_done_stops: assert property (@(posedge clock) disable iff (reset)
      accept && walk_ev.has_result && walk_ev.done |=> !walk_active)
      else $error("walk still active after its final event");

   a_non_ep_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.event_kind != ucdp_pkg::EV_ENDPOINT |->
      rsp_data_ff.max_packet_in == 16'd0 && rsp_data_ff.max_packet_out == 16'd0 &&
      rsp_data_ff.endpoint_number == 4'd0 && !rsp_data_ff.is_in)
      else $error("endpoint fields set on a non-endpoint event");

endmodule

// ===== bench/usb_config_descriptor_parser_tb.sv =====
`timescale 1ns / 100ps

module usb_config_descriptor_parser_tb;
   import ucdp_pkg::*;

   localparam int PERIOD       = 20;
   localparam int PHASES       = 5;
   localparam int PHASE_BYTES  = 320;
   localparam int SETTLE       = 10;
   localparam int LIMIT_CYCLES = 600_000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_wr_en = 1'b0;
   logic [7:0]  csr_wr_data = 8'd0;

   usb_config_descriptor_parser i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // bytes waiting to be sent, events waiting to be seen
   req_type    byte_backlog[$];
   rsp_type    event_due[$];
   logic [7:0] set_bytes[$];
   int         fail_count = 0;

   // walker state kept by the bench
   logic [7:0]  ep0_size;
   logic [15:0] w_offset, w_total, w_start;
   logic [7:0]  w_len, w_type;
   logic [31:0] w_fields;
   logic [7:0]  w_decl_ifaces;
   logic [3:0]  w_ifaces;
   logic [8:0]  w_iface_num;
   logic [7:0]  w_decl_eps;
   logic [4:0]  w_eps;
   logic [7:0]  w_alts;
   logic [15:0] in_size [EP_NUMBERS];
   logic [15:0] out_size [EP_NUMBERS];
   logic        w_active;

   function automatic void restart_walk();
      int k;
      w_offset = 0;
      w_total = 0;
      w_start = 0;
      w_len = 0;
      w_type = 0;
      w_fields = 0;
      w_decl_ifaces = 0;
      w_ifaces = 0;
      w_iface_num = NO_IFACE;
      w_decl_eps = 0;
      w_eps = 0;
      w_alts = 0;
      for (k = 0; k < EP_NUMBERS; k++) begin
         in_size[k] = 16'd0;
         out_size[k] = 16'd0;
      end
      in_size[0] = {8'h00, ep0_size};
      out_size[0] = {8'h00, ep0_size};
      w_active = 1'b0;
   endfunction

   // advance the walk by one byte; returns 1 when the byte ends a descriptor event
   function automatic bit walk_byte(input req_type r, output rsp_type ev);
      int unsigned    pos, nxt;
      logic [7:0]     b, addr, attr;
      logic [15:0]    pkt;
      logic [3:0]     epn;
      logic           in_dir, fin, last, has;
      event_kind_type kind;
      b = r.data_byte;
      ev = '0;
      has = 1'b0;
      fin = 1'b0;
      last = 1'b0;
      epn = 4'd0;
      in_dir = 1'b0;
      kind = EV_OTHER;
      if (r.first) begin
         restart_walk();
         w_active = 1'b1;
      end
      if (!w_active)
         return 1'b0;

      pos = {16'd0, w_offset};
      if (pos == 0) begin
         w_len = b;
         w_type = 8'd0;
         w_fields = 32'd0;
      end else if (pos == 1) begin
         w_type = b;
      end else if (pos < 6) begin
         w_fields[8*(pos-2) +: 8] = b;
      end

      if (w_len == 0) begin
         kind = EV_ZERO_LEN;
         has = 1'b1;
         fin = 1'b1;
      end else if (w_start == 0 && pos == 0 && w_len == 1) begin
         kind = EV_NOT_CONFIG;
         has = 1'b1;
         fin = 1'b1;
      end else if (w_start == 0 && pos == 1 && w_type != DT_CONFIG) begin
         kind = EV_NOT_CONFIG;
         has = 1'b1;
         fin = 1'b1;
      end else if (pos + 1 == w_len) begin
         last = 1'b1;
         has = 1'b1;
         if (w_start == 0) begin
            w_total = w_fields[15:0];
            w_decl_ifaces = w_fields[23:16];
            kind = EV_CONFIG_OK;
         end else if (w_type == DT_INTERFACE) begin
            if ({1'b0, w_fields[7:0]} != w_iface_num) begin
               if (w_ifaces >= MAX_INTERFACES) begin
                  kind = EV_ERROR;
                  fin = 1'b1;
               end else begin
                  w_ifaces = w_ifaces + 4'd1;
                  w_alts = 8'd1;
                  w_eps = 5'd0;
                  w_decl_eps = w_fields[23:16];
                  w_iface_num = {1'b0, w_fields[7:0]};
                  kind = EV_NEW_IFACE;
               end
            end else begin
               if (w_alts != 8'hFF)
                  w_alts = w_alts + 8'd1;
               kind = EV_ALT_SET;
            end
         end else if (w_type == DT_ENDPOINT) begin
            if (w_ifaces == 0 || w_eps >= MAX_EP_PER_IFACE) begin
               kind = EV_ERROR;
               fin = 1'b1;
            end else begin
               addr = w_fields[7:0];
               attr = w_fields[15:8];
               pkt = w_fields[31:16];
               epn = addr[3:0];
               in_dir = addr[7];
               // only endpoints inside the declared counts touch the tables
               if ({4'd0, w_ifaces} - 8'd1 < w_decl_ifaces && {3'd0, w_eps} < w_decl_eps) begin
                  if (attr[1:0] == 2'b00) begin
                     in_size[epn] = pkt;
                     out_size[epn] = pkt;
                  end else if (in_dir) begin
                     if (pkt > in_size[epn])
                        in_size[epn] = pkt;
                  end else begin
                     if (pkt > out_size[epn])
                        out_size[epn] = pkt;
                  end
               end
               w_eps = w_eps + 5'd1;
               kind = EV_ENDPOINT;
            end
         end else if (w_type == DT_SS_COMP) begin
            if (w_ifaces == 0 || w_eps == 0) begin
               kind = EV_ERROR;
               fin = 1'b1;
            end else begin
               kind = EV_SS_COMP;
            end
         end else begin
            kind = EV_OTHER;
         end
      end

      if (last && !fin) begin
         nxt = {16'd0, w_start} + {24'd0, w_len};
         if (nxt + 1 >= w_total) begin
            fin = 1'b1;
         end else begin
            w_start = nxt[15:0];
            w_offset = 16'd0;
         end
      end else if (!fin) begin
         w_offset = w_offset + 16'd1;
      end
      if (fin)
         w_active = 1'b0;
      if (!has)
         return 1'b0;

      ev.event_kind = kind;
      ev.interface_slot = (w_ifaces == 0) ? 3'd0 : w_ifaces[2:0] - 3'd1;
      ev.interface_count = w_ifaces;
      ev.alt_count = w_alts;
      ev.endpoint_slot = w_eps;
      ev.endpoint_number = epn;
      ev.is_in = in_dir;
      ev.max_packet_in = (kind == EV_ENDPOINT) ? in_size[epn] : 16'd0;
      ev.max_packet_out = (kind == EV_ENDPOINT) ? out_size[epn] : 16'd0;
      ev.done_res = fin;
      return 1'b1;
   endfunction

   function automatic bit same_event(input rsp_type a, input rsp_type b);
      return a.event_kind === b.event_kind && a.interface_slot === b.interface_slot &&
             a.interface_count === b.interface_count && a.alt_count === b.alt_count &&
             a.endpoint_slot === b.endpoint_slot && a.endpoint_number === b.endpoint_number &&
             a.is_in === b.is_in && a.max_packet_in === b.max_packet_in &&
             a.max_packet_out === b.max_packet_out && a.done_res === b.done_res;
   endfunction

   function automatic string show(input rsp_type r);
      return $sformatf("kind=%0d slot=%0d ifaces=%0d alts=%0d eps=%0d epn=%0d in=%0b %s",
                       r.event_kind, r.interface_slot, r.interface_count, r.alt_count,
                       r.endpoint_slot, r.endpoint_number, r.is_in,
                       $sformatf("mps_in=%0h mps_out=%0h done=%0b",
                                 r.max_packet_in, r.max_packet_out, r.done_res));
   endfunction

   function automatic void note_failure(input string msg);
      fail_count++;
      if (fail_count <= 10)
         $display("%0t: %s", $realtime, msg);
   endfunction

   // per-beat wait, with occasional stretches of back-to-back beats
   function automatic int draw_wait(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 63) == 0) begin
         calm = $urandom_range(20, 80);
         return 0;
      end
      return $urandom_range(0, 19);
   endfunction

   function automatic logic [7:0] rand_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic void push_beat(input logic [7:0] d, input logic f);
      req_type r;
      r.data_byte = d;
      r.first = f;
      byte_backlog.push_back(r);
   endfunction

   function automatic void add_desc(input int len, input logic [7:0] dtype,
                                    input logic [31:0] fields);
      int k;
      set_bytes.push_back(len[7:0]);
      for (k = 1; k < len; k++) begin
         if (k == 1)
            set_bytes.push_back(dtype);
         else if (k < 6)
            set_bytes.push_back(fields[8*(k-2) +: 8]);
         else
            set_bytes.push_back(rand_byte());
      end
   endfunction

   function automatic logic [31:0] ep_fields();
      logic [31:0] f;
      f[7:0] = rand_byte();
      f[15:8] = rand_byte();
      if ($urandom_range(0, 2) == 0)
         f[9:8] = 2'b00;
      case ($urandom_range(0, 7))
         0: f[31:16] = 16'($urandom_range(0, 65535));
         1: f[31:16] = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         default: f[31:16] = 16'($urandom_range(0, 1024));
      endcase
      return f;
   endfunction

   function automatic logic [31:0] rand_word();
      return {rand_byte(), rand_byte(), rand_byte(), rand_byte()};
   endfunction

   // one descriptor set, mostly well formed; returns the number of beats queued
   function automatic int add_random_set();
      int          n_if, n_ep, i, e, k, hdr_len, total, cut, noise, sent;
      logic [7:0]  num, decl_if, decl_ep, hdr_type;
      logic [31:0] f;
      set_bytes.delete();
      n_if = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 11) : $urandom_range(1, 3);
      decl_if = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 10)) : 8'(n_if);
      hdr_len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 12) : 9;
      hdr_type = ($urandom_range(0, 24) == 0) ? rand_byte() : DT_CONFIG;
      f = rand_word();
      f[23:16] = decl_if;
      add_desc(hdr_len, hdr_type, f);

      // orphans: endpoint or companion ahead of any interface
      if ($urandom_range(0, 11) == 0)
         add_desc(7, DT_ENDPOINT, ep_fields());
      if ($urandom_range(0, 14) == 0)
         add_desc(6, DT_SS_COMP, rand_word());

      num = 8'($urandom_range(0, 3));
      for (i = 0; i < n_if; i++) begin
         if (i > 0) begin
            if ($urandom_range(0, 7) == 0)
               num = rand_byte();
            else if ($urandom_range(0, 3) != 0)
               num = num + 8'd1;
         end
         n_ep = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 18) : $urandom_range(0, 4);
         decl_ep = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 20)) : 8'(n_ep);
         f = rand_word();
         f[7:0] = num;
         f[23:16] = decl_ep;
         add_desc(($urandom_range(0, 9) == 0) ? $urandom_range(2, 12) : 9, DT_INTERFACE, f);
         if ($urandom_range(0, 9) == 0)
            add_desc(6, DT_SS_COMP, rand_word());
         for (e = 0; e < n_ep; e++) begin
            if ($urandom_range(0, 7) == 0)
               add_desc($urandom_range(2, 10), rand_byte(), rand_word());
            if ($urandom_range(0, 39) == 0)
               add_desc($urandom_range(0, 1), rand_byte(), rand_word());
            add_desc(($urandom_range(0, 9) == 0) ? $urandom_range(2, 9) : 7,
                     DT_ENDPOINT, ep_fields());
            if ($urandom_range(0, 3) == 0)
               add_desc(6, DT_SS_COMP, rand_word());
         end
      end
      if ($urandom_range(0, 11) == 0)
         add_desc($urandom_range(0, 1), rand_byte(), rand_word());

      total = set_bytes.size();
      case ($urandom_range(0, 9))
         0: total = $urandom_range(0, total);
         1: total = total + $urandom_range(1, 20);
         2: total = $urandom_range(0, 1) ? 65535 : 0;
         default: ;
      endcase
      if (hdr_len > 2)
         set_bytes[2] = total[7:0];
      if (hdr_len > 3)
         set_bytes[3] = total[15:8];

      // sometimes cut short so that the next set restarts mid-walk
      cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, set_bytes.size())
                                         : set_bytes.size();
      for (k = 0; k < cut; k++)
         push_beat(set_bytes[k], k == 0);
      sent = cut;
      if ($urandom_range(0, 4) == 0) begin
         noise = $urandom_range(1, 6);
         for (k = 0; k < noise; k++)
            push_beat(rand_byte(), $urandom_range(0, 15) == 0);
         sent += noise;
      end
      return sent;
   endfunction

   task automatic write_ep0(input logic [7:0] v);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      ep0_size = v;
   endtask

   task automatic wait_drained();
      while (byte_backlog.size() != 0 || req_valid || event_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   initial begin
      forever #(PERIOD / 2) clock = ~clock;
   end

   initial begin
      #(PERIOD * LIMIT_CYCLES);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // driver: predicts each accepted beat
   int      req_gap = 0;
   int      req_calm = 0;
   rsp_type acc_ev;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_valid && !req_stall) begin
            if (walk_byte(req_data, acc_ev))
               event_due.push_back(acc_ev);
         end
         if (!req_valid || !req_stall) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (byte_backlog.size() != 0) begin
               req_data <= byte_backlog.pop_front();
               req_valid <= 1'b1;
               req_gap = draw_wait(req_calm);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   int      rsp_hold = 0;
   int      rsp_calm = 0;
   rsp_type want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (event_due.size() == 0) begin
               note_failure({"unexpected event: ", show(rsp_data)});
            end else begin
               want = event_due.pop_front();
               if (!same_event(want, rsp_data))
                  note_failure({"event differs\n  expected ", show(want),
                                "\n  actual   ", show(rsp_data)});
            end
            rsp_hold = draw_wait(rsp_calm);
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      int         p, sent;
      logic [7:0] ep0_pick;
      ep0_size = EP0_RESET_SIZE;
      restart_walk();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (p = 0; p < PHASES; p++) begin
         case (p)
            0: ep0_pick = 8'hFF;
            1: ep0_pick = 8'h00;
            4: ep0_pick = EP0_RESET_SIZE;
            default: ep0_pick = rand_byte();
         endcase
         write_ep0(ep0_pick);
         @(negedge clock);
         sent = 0;
         if (p == 0) begin
            // byte while no walk is active, then zero length and both bad headers
            push_beat(8'h5A, 1'b0);
            push_beat(8'h00, 1'b1);
            push_beat(8'h01, 1'b1);
            push_beat(8'h09, 1'b1);
            push_beat(8'h07, 1'b0);
            // short header, one interface, control endpoint 15 IN at full size
            push_beat(8'h05, 1'b1);
            push_beat(DT_CONFIG, 1'b0);
            push_beat(8'h10, 1'b0);
            push_beat(8'h00, 1'b0);
            push_beat(8'h01, 1'b0);
            push_beat(8'h05, 1'b0);
            push_beat(DT_INTERFACE, 1'b0);
            push_beat(8'hFF, 1'b0);
            push_beat(8'h00, 1'b0);
            push_beat(8'h01, 1'b0);
            push_beat(8'h06, 1'b0);
            push_beat(DT_ENDPOINT, 1'b0);
            push_beat(8'h8F, 1'b0);
            push_beat(8'h00, 1'b0);
            push_beat(8'hFF, 1'b0);
            push_beat(8'hFF, 1'b0);
            // header of length two: total length reads as zero
            push_beat(8'h02, 1'b1);
            push_beat(DT_CONFIG, 1'b0);
         end
         while (sent < PHASE_BYTES)
            sent += add_random_set();
         wait_drained();
      end

      if (fail_count == 0 && event_due.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/ucdp_pkg.sv
rtl/ucdp_walker.sv
rtl/ucdp_ep_table.sv
rtl/usb_config_descriptor_parser.sv
bench/usb_config_descriptor_parser_tb.sv
